FILE: src/jspp_pkg.sv
`timescale 1ns / 1ps
package jspp_pkg;

	localparam int MaxDepth = 32;
	localparam int DepthW = 6;
	localparam int StackAw = 5;
	localparam int MaxRes = 5;
	localparam int ResCntW = 3;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 5;

	localparam logic [CfgIdxW-1:0] CFG_INDENT_WIDTH = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_INDENT_TABS = 2'd1;

	localparam logic [3:0] ERR_NONE = 4'd0;
	localparam logic [3:0] ERR_STRING = 4'd1;
	localparam logic [3:0] ERR_COLON = 4'd2;
	localparam logic [3:0] ERR_ARR = 4'd3;
	localparam logic [3:0] ERR_OBJ = 4'd4;
	localparam logic [3:0] ERR_VALUE = 4'd5;
	localparam logic [3:0] ERR_UNT_STR = 4'd6;
	localparam logic [3:0] ERR_UNT_ARR = 4'd7;
	localparam logic [3:0] ERR_UNT_OBJ = 4'd8;
	localparam logic [3:0] ERR_TRAILING = 4'd9;
	localparam logic [3:0] ERR_DEEP = 4'd10;

	typedef enum logic [3:0] {
		PH_TOP, PH_ARR_FIRST, PH_ARR_NEXT, PH_OBJ_FIRST, PH_OBJ_NEXT, PH_COLON,
		PH_OBJ_VALUE, PH_AFTER, PH_STRING, PH_KEY, PH_LIT_TRUE, PH_LIT_FALSE,
		PH_LIT_NULL, PH_NUM, PH_NUM_SIGN, PH_ERR
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_document;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [9:0]  run_length;
		logic [3:0]  error_code;
		logic [31:0] error_offset;
		logic        document_done;
		logic        last_of_run;
	} out_item_t;

	function automatic logic [7:0] lit_char(input phase_t ph, input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		unique case (ph)
			PH_LIT_TRUE: begin
				unique case (idx)
					4'd0: r = "t";
					4'd1: r = "r";
					4'd2: r = "u";
					4'd3: r = "e";
					default: r = 8'h00;
				endcase
			end
			PH_LIT_FALSE: begin
				unique case (idx)
					4'd0: r = "f";
					4'd1: r = "a";
					4'd2: r = "l";
					4'd3: r = "s";
					4'd4: r = "e";
					default: r = 8'h00;
				endcase
			end
			PH_LIT_NULL: begin
				unique case (idx)
					4'd0: r = "n";
					4'd1: r = "u";
					4'd2: r = "l";
					4'd3: r = "l";
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] lit_len(input phase_t ph);
		return (ph == PH_LIT_FALSE) ? 4'd5 : 4'd4;
	endfunction

endpackage

FILE: src/json_stream_pretty_printer.sv
`timescale 1ns / 1ps
// Streaming JSON pretty printer. One document enters as a request per byte on
// the in channel (in_valid, in_stall, in_data); end_of_document marks its end.
// Each input request yields zero to four output requests on the out channel,
// each a character with a repeat count, or one status request on an error.
// The parser takes one input request per cycle unless in_stall is high, and its
// results are registered, so the first result appears in the cycle after
// acceptance. An input whose results are several holds the next input until
// its last result is taken; an input with one result sustains one request per
// cycle. The nesting-kind stack sits in a 32-entry memory with a registered
// read; the top entry is fetched ahead and forwarded after a push, so it never
// stalls. While out_stall is high the current result holds and further input
// is stalled while any result is pending. Reset clears the parser state,
// empties the result buffer and loads indent width 2 with spaces.
// Configuration writes through cfg_wr_en, cfg_index and cfg_data take effect
// at once and must be made while the block is idle.
module json_stream_pretty_printer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  jspp_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output jspp_pkg::out_item_t                  out_data,
	input  logic                                 cfg_wr_en,
	input  logic [jspp_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [jspp_pkg::CfgDataW-1:0]        cfg_data
);

	logic [4:0] indent_width_q;
	logic indent_tabs_q;

	jspp_pkg::phase_t phase_q, n_phase;
	logic [jspp_pkg::DepthW-1:0] depth_q, n_depth, next_depth, ind_lv;
	logic esc_q, n_esc;
	logic [3:0] lit_q, n_lit;
	logic [31:0] off_q, n_off, back_lit, back_one;

	logic stack_mem [jspp_pkg::MaxDepth];
	logic [jspp_pkg::StackAw-1:0] rd_addr;
	logic rd_q, fwd_q, wkind_q, top_kind;
	logic push, push_kind, pop;

	jspp_pkg::out_item_t buf_q [jspp_pkg::MaxRes];
	jspp_pkg::out_item_t list [jspp_pkg::MaxRes];
	jspp_pkg::out_item_t cand [jspp_pkg::MaxRes];
	logic [jspp_pkg::MaxRes-1:0] cv;
	logic [jspp_pkg::ResCntW-1:0] cnt_q, idx_q, n_res;

	logic accept, out_go, last_go;
	logic [7:0] c;
	logic eod, ws, digit;
	logic e_comma, e_nl, e_ind, e_c1, e_c2, done_ok;
	logic [7:0] c1, c2;
	logic do_start, do_after, fail;
	logic [3:0] fcode;
	logic [31:0] foff;
	logic [4:0] wclamp;
	logic [10:0] ind_prod;
	logic [9:0] ind_run;

	assign out_valid = (cnt_q != '0);
	assign out_data = buf_q[idx_q];
	assign out_go = out_valid && !out_stall;
	assign last_go = out_go && (idx_q == cnt_q - 3'd1);
	assign in_stall = out_valid && !last_go;
	assign accept = in_valid && !in_stall;

	assign c = in_data.byte_value;
	assign eod = in_data.end_of_document;
	assign ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	assign digit = (c >= "0") && (c <= "9");
	assign top_kind = fwd_q ? wkind_q : rd_q;
	assign back_lit = (off_q >= {28'd0, lit_q}) ? off_q - {28'd0, lit_q} : 32'd0;
	assign back_one = (off_q >= 32'd1) ? off_q - 32'd1 : 32'd0;
	assign wclamp = (indent_width_q > 5'd16) ? 5'd16 : indent_width_q;
	assign ind_prod = {5'd0, ind_lv} * {6'd0, wclamp};
	assign ind_run = indent_tabs_q ? {4'd0, ind_lv} : ind_prod[9:0];

	always_comb begin
		n_phase = phase_q;
		n_depth = depth_q;
		n_esc = esc_q;
		n_lit = lit_q;
		n_off = off_q;
		push = 1'b0;
		push_kind = 1'b0;
		pop = 1'b0;
		e_comma = 1'b0;
		e_nl = 1'b0;
		e_ind = 1'b0;
		ind_lv = depth_q;
		e_c1 = 1'b0;
		c1 = c;
		e_c2 = 1'b0;
		c2 = 8'h20;
		done_ok = 1'b0;
		do_start = 1'b0;
		do_after = 1'b0;
		fail = 1'b0;
		fcode = jspp_pkg::ERR_NONE;
		foff = off_q;
		if (phase_q == jspp_pkg::PH_ERR) begin
			if (eod) begin
				n_phase = jspp_pkg::PH_TOP;
				n_depth = '0;
				n_esc = 1'b0;
				n_lit = '0;
				n_off = '0;
			end
		end else if (eod) begin
			unique case (phase_q)
				jspp_pkg::PH_TOP, jspp_pkg::PH_OBJ_VALUE: begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_VALUE;
				end
				jspp_pkg::PH_ARR_FIRST, jspp_pkg::PH_ARR_NEXT: begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_UNT_ARR;
				end
				jspp_pkg::PH_OBJ_FIRST, jspp_pkg::PH_OBJ_NEXT: begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_UNT_OBJ;
				end
				jspp_pkg::PH_COLON: begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_COLON;
				end
				jspp_pkg::PH_STRING, jspp_pkg::PH_KEY: begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_UNT_STR;
				end
				jspp_pkg::PH_LIT_TRUE, jspp_pkg::PH_LIT_FALSE, jspp_pkg::PH_LIT_NULL: begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_VALUE;
					foff = back_lit;
				end
				jspp_pkg::PH_NUM_SIGN: begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_VALUE;
					foff = back_one;
				end
				default: begin
					if (depth_q == '0) begin
						e_nl = 1'b1;
						done_ok = 1'b1;
					end else begin
						fail = 1'b1;
						fcode = top_kind ? jspp_pkg::ERR_OBJ : jspp_pkg::ERR_ARR;
					end
				end
			endcase
			n_phase = jspp_pkg::PH_TOP;
			n_depth = '0;
			n_esc = 1'b0;
			n_lit = '0;
			n_off = '0;
		end else begin
			unique case (phase_q)
				jspp_pkg::PH_TOP, jspp_pkg::PH_OBJ_VALUE: begin
					do_start = !ws;
				end
				jspp_pkg::PH_ARR_FIRST, jspp_pkg::PH_ARR_NEXT,
				jspp_pkg::PH_OBJ_FIRST, jspp_pkg::PH_OBJ_NEXT: begin
					if (!ws) begin
						if ((c == "]" && (phase_q == jspp_pkg::PH_ARR_FIRST ||
						    phase_q == jspp_pkg::PH_ARR_NEXT)) ||
						    (c == "}" && (phase_q == jspp_pkg::PH_OBJ_FIRST ||
						    phase_q == jspp_pkg::PH_OBJ_NEXT))) begin
							if (depth_q == '0) begin
								fail = 1'b1;
								fcode = jspp_pkg::ERR_ARR;
							end else begin
								e_nl = (phase_q == jspp_pkg::PH_ARR_NEXT) ||
									(phase_q == jspp_pkg::PH_OBJ_NEXT);
								e_ind = e_nl;
								ind_lv = depth_q - 6'd1;
								e_c1 = 1'b1;
								pop = 1'b1;
								n_depth = depth_q - 6'd1;
								n_phase = jspp_pkg::PH_AFTER;
							end
						end else begin
							e_comma = (phase_q == jspp_pkg::PH_ARR_NEXT) ||
								(phase_q == jspp_pkg::PH_OBJ_NEXT);
							e_nl = 1'b1;
							e_ind = 1'b1;
							if (phase_q == jspp_pkg::PH_ARR_FIRST ||
							    phase_q == jspp_pkg::PH_ARR_NEXT) begin
								do_start = 1'b1;
							end else if (c == "\"") begin
								e_c1 = 1'b1;
								n_esc = 1'b0;
								n_phase = jspp_pkg::PH_KEY;
							end else begin
								fail = 1'b1;
								fcode = jspp_pkg::ERR_STRING;
							end
						end
					end
				end
				jspp_pkg::PH_COLON: begin
					if (!ws) begin
						if (c == ":") begin
							e_c1 = 1'b1;
							e_c2 = 1'b1;
							n_phase = jspp_pkg::PH_OBJ_VALUE;
						end else begin
							fail = 1'b1;
							fcode = jspp_pkg::ERR_COLON;
						end
					end
				end
				jspp_pkg::PH_STRING, jspp_pkg::PH_KEY: begin
					e_c1 = 1'b1;
					if (esc_q) begin
						n_esc = 1'b0;
					end else if (c == "\\") begin
						n_esc = 1'b1;
					end else if (c == "\"") begin
						n_phase = (phase_q == jspp_pkg::PH_KEY) ? jspp_pkg::PH_COLON :
							jspp_pkg::PH_AFTER;
					end
				end
				jspp_pkg::PH_LIT_TRUE, jspp_pkg::PH_LIT_FALSE, jspp_pkg::PH_LIT_NULL: begin
					if (lit_q < jspp_pkg::lit_len(phase_q) &&
					    c == jspp_pkg::lit_char(phase_q, lit_q)) begin
						e_c1 = 1'b1;
						n_lit = lit_q + 4'd1;
						if (lit_q + 4'd1 >= jspp_pkg::lit_len(phase_q)) begin
							n_lit = '0;
							n_phase = jspp_pkg::PH_AFTER;
						end
					end else begin
						fail = 1'b1;
						fcode = jspp_pkg::ERR_VALUE;
						foff = back_lit;
					end
				end
				jspp_pkg::PH_NUM_SIGN: begin
					if (digit) begin
						e_c1 = 1'b1;
						n_phase = jspp_pkg::PH_NUM;
					end else begin
						fail = 1'b1;
						fcode = jspp_pkg::ERR_VALUE;
						foff = back_one;
					end
				end
				jspp_pkg::PH_NUM: begin
					if (digit || c == "." || c == "e" || c == "E" || c == "+" || c == "-") begin
						e_c1 = 1'b1;
					end else begin
						n_phase = jspp_pkg::PH_AFTER;
						do_after = 1'b1;
					end
				end
				default: begin
					do_after = 1'b1;
				end
			endcase
			if (do_start) begin
				if (c == "{" || c == "[") begin
					if (depth_q >= 6'(jspp_pkg::MaxDepth)) begin
						fail = 1'b1;
						fcode = jspp_pkg::ERR_DEEP;
					end else begin
						push = 1'b1;
						push_kind = (c == "{");
						n_depth = depth_q + 6'd1;
						e_c1 = 1'b1;
						n_phase = (c == "{") ? jspp_pkg::PH_OBJ_FIRST : jspp_pkg::PH_ARR_FIRST;
					end
				end else if (c == "\"") begin
					e_c1 = 1'b1;
					n_esc = 1'b0;
					n_phase = jspp_pkg::PH_STRING;
				end else if (c == "t" || c == "f" || c == "n") begin
					e_c1 = 1'b1;
					n_lit = 4'd1;
					n_phase = (c == "t") ? jspp_pkg::PH_LIT_TRUE :
						(c == "f") ? jspp_pkg::PH_LIT_FALSE : jspp_pkg::PH_LIT_NULL;
				end else if (c == "-") begin
					e_c1 = 1'b1;
					n_phase = jspp_pkg::PH_NUM_SIGN;
				end else if (digit) begin
					e_c1 = 1'b1;
					n_phase = jspp_pkg::PH_NUM;
				end else begin
					fail = 1'b1;
					fcode = jspp_pkg::ERR_VALUE;
				end
			end
			if (do_after) begin
				if (depth_q == '0) begin
					if (!ws) begin
						fail = 1'b1;
						fcode = jspp_pkg::ERR_TRAILING;
					end
				end else if (!ws) begin
					if (c == ",") begin
						n_phase = top_kind ? jspp_pkg::PH_OBJ_NEXT : jspp_pkg::PH_ARR_NEXT;
					end else if (c == (top_kind ? 8'h7D : 8'h5D)) begin
						e_nl = 1'b1;
						e_ind = 1'b1;
						ind_lv = depth_q - 6'd1;
						e_c1 = 1'b1;
						pop = 1'b1;
						n_depth = depth_q - 6'd1;
						n_phase = jspp_pkg::PH_AFTER;
					end else begin
						fail = 1'b1;
						fcode = top_kind ? jspp_pkg::ERR_OBJ : jspp_pkg::ERR_ARR;
					end
				end
			end
			if (fail) begin
				n_phase = jspp_pkg::PH_ERR;
				push = 1'b0;
				pop = 1'b0;
				n_depth = depth_q;
			end else if (off_q != 32'hFFFF_FFFF) begin
				n_off = off_q + 32'd1;
			end
		end
	end

	always_comb begin
		cand[0] = '{out_byte: ",", run_length: 10'd1, default: '0};
		cand[1] = '{out_byte: 8'h0A, run_length: 10'd1, default: '0};
		cand[2] = '{out_byte: indent_tabs_q ? 8'h09 : 8'h20, run_length: ind_run,
			default: '0};
		cand[3] = '{out_byte: c1, run_length: 10'd1, default: '0};
		cand[4] = '{out_byte: c2, run_length: 10'd1, default: '0};
		cv = {e_c2, e_c1, e_ind && (ind_run != '0), e_nl, e_comma};
		n_res = '0;
		for (int k = 0; k < jspp_pkg::MaxRes; k++) begin
			list[k] = '0;
		end
		for (int k = 0; k < jspp_pkg::MaxRes; k++) begin
			if (cv[k]) begin
				list[n_res] = cand[k];
				n_res = n_res + 3'd1;
			end
		end
		if (fail) begin
			list[0] = '{error_code: fcode, error_offset: foff, document_done: 1'b1,
				default: '0};
			n_res = 3'd1;
		end
		if (n_res != '0) begin
			list[n_res - 3'd1].last_of_run = 1'b1;
			if (done_ok) begin
				list[n_res - 3'd1].document_done = 1'b1;
			end
		end
	end

	assign next_depth = accept ? n_depth : depth_q;
	assign rd_addr = 5'(next_depth - 6'd1);

	always_ff @(posedge clk) begin
		if (accept && push) begin
			stack_mem[depth_q[jspp_pkg::StackAw-1:0]] <= push_kind;
		end
		rd_q <= stack_mem[rd_addr];
		wkind_q <= push_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= accept && push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indent_width_q <= 5'd2;
			indent_tabs_q <= 1'b0;
		end else if (cfg_wr_en) begin
			if (cfg_index == jspp_pkg::CFG_INDENT_WIDTH) begin
				indent_width_q <= cfg_data;
			end else if (cfg_index == jspp_pkg::CFG_INDENT_TABS) begin
				indent_tabs_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jspp_pkg::PH_TOP;
			depth_q <= '0;
			esc_q <= 1'b0;
			lit_q <= '0;
			off_q <= '0;
		end else if (accept) begin
			phase_q <= n_phase;
			depth_q <= n_depth;
			esc_q <= n_esc;
			lit_q <= n_lit;
			off_q <= n_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			cnt_q <= n_res;
			idx_q <= '0;
		end else if (last_go) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (out_go) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < jspp_pkg::MaxRes; k++) begin
				buf_q[k] <= list[k];
			end
		end
	end

endmodule

FILE: src/jspp_checker.sv
`timescale 1ns / 1ps
module jspp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input jspp_pkg::out_item_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("Stalled result changed.");

	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != jspp_pkg::ERR_NONE |->
		out_data.run_length == '0 && out_data.document_done && out_data.last_of_run)
		else $error("Error result is not a lone final status request.");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.error_code <= jspp_pkg::ERR_DEEP)
		else $error("Error code out of range.");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code == jspp_pkg::ERR_NONE |->
		out_data.run_length != '0 && out_data.error_offset == '0)
		else $error("Character result is malformed.");

endmodule

bind json_stream_pretty_printer jspp_checker u_jspp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
